FILE: design/rwpq_pkg.sv
// shared types and constants for the read/write priority request queue
`timescale 1ns / 1ps
package rwpq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    typedef enum logic [1:0] {
        CMD_SUBMIT = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_SERVE  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_FAIR   = 2'd0,
        MODE_READS  = 2'd1,
        MODE_WRITES = 2'd2,
        MODE_ALT    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SERVE_RD,
        S_SERVE_WR,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        is_write;
        logic [15:0] request_tag;
        logic [7:0]  file_id;
        logic [47:0] block_offset;
    } req_t;

    typedef struct packed {
        logic        hazard;
        logic        overflow;
        logic        cancel_found;
        logic        served_valid;
        logic [15:0] served_tag;
        logic        served_is_write;
    } rsp_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [7:0]  file_id;
        logic [47:0] offset;
    } entry_t;

endpackage

FILE: design/rwpq_ram.sv
// simple dual-port ram with registered read data
`timescale 1ns / 1ps
module rwpq_ram #(
    parameter int ENTRIES = 32,
    parameter int DATA_W  = 72,
    parameter int ADDR_W  = 5
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/read_write_priority_request_queue.sv
// Read/write request queue with priority arbiter.
// Requests come in on req (req_valid/req_ready), one result per request
// leaves on rsp (rsp_valid/rsp_ready). cfg_we writes the priority mode.
// Both queues are circular buffers in one ram, one entry read and one
// written per cycle, head pointers and counts kept in flops.
// Steps per request, each ending in the output register:
//   submit: scan of the opposite queue for a hazard, then append
//   cancel: scan of its own queue for the tag, then a read and a write
//           to shift each later entry down; not found: scan only
//   serve:  read of the queue head; empty serve, unknown command: result only
// The scan goes through the single ram read port; one request is
// processed at a time.
// A finished result sits in an output register; the next request is taken
// while it waits, and the block holds its next result until rsp_ready.
// Reset empties both queues, clears the priority mode to fair alternation
// and starts in the write phase. Queue contents are not cleared.
`timescale 1ns / 1ps
module read_write_priority_request_queue #(
    parameter int QUEUE_DEPTH = rwpq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_wdata,
    input  logic           req_valid,
    output logic           req_ready,
    input  rwpq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output rwpq_pkg::rsp_t rsp
);
    import rwpq_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int SW = PW + 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(2 * QUEUE_DEPTH);
    localparam int DW = $bits(entry_t);

    state_t          state_reg, state_next;
    req_t            req_reg, req_next;
    rsp_t            res_reg, res_next;
    rsp_t            rsp_reg, rsp_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic            sq_reg, sq_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   ridx_reg, ridx_next;
    logic            rv_reg, rv_next;
    logic            hit_reg, hit_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [CW-1:0]   rd_count_reg, rd_count_next;
    logic [CW-1:0]   wr_count_reg, wr_count_next;
    logic [PW-1:0]   rd_head_reg, rd_head_next;
    logic [PW-1:0]   wr_head_reg, wr_head_next;
    logic            turn_reg, turn_next;
    logic [1:0]      mode_reg;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    entry_t          ram_wdata;
    entry_t          ram_rdata;
    logic [DW-1:0]   ram_rbits;

    logic [CW-1:0]   sel_count;
    logic [PW-1:0]   sel_head;
    logic [SW-1:0]   head_inc;
    logic            issue;
    logic            served_q;

    function automatic logic [AW-1:0] phys(input logic q, input logic [PW-1:0] head,
                                           input logic [CW-1:0] idx);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(idx);
        if (sum >= SW'(QUEUE_DEPTH))
        begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return q ? AW'(sum[PW-1:0]) + AW'(QUEUE_DEPTH) : AW'(sum[PW-1:0]);
    endfunction

    rwpq_ram #(
        .ENTRIES(2 * QUEUE_DEPTH),
        .DATA_W (DW),
        .ADDR_W (AW)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rbits)
    );

    assign ram_rdata = entry_t'(ram_rbits);
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign sel_count = sq_reg ? wr_count_reg : rd_count_reg;
    assign sel_head  = sq_reg ? wr_head_reg : rd_head_reg;
    assign head_inc  = SW'(sel_head) + SW'(1);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        sq_next        = sq_reg;
        idx_next       = idx_reg;
        ridx_next      = ridx_reg;
        rv_next        = 1'b0;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        rd_count_next  = rd_count_reg;
        wr_count_next  = wr_count_reg;
        rd_head_next   = rd_head_reg;
        wr_head_next   = wr_head_reg;
        turn_next      = turn_reg;
        ram_we         = 1'b0;
        ram_waddr      = phys(sq_reg, sel_head, pos_reg);
        ram_wdata      = ram_rdata;
        ram_raddr      = phys(sq_reg, sel_head, idx_reg);
        issue          = 1'b0;
        served_q       = sq_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    res_next = '0;
                    idx_next = '0;
                    hit_next = 1'b0;
                    case (req.cmd)
                        CMD_SUBMIT:
                        begin
                            sq_next    = ~req.is_write;
                            state_next = S_SCAN;
                        end
                        CMD_CANCEL:
                        begin
                            sq_next    = req.is_write;
                            state_next = S_SCAN;
                        end
                        CMD_SERVE:
                        begin
                            if (rd_count_reg == '0 && wr_count_reg == '0)
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                served_q = turn_reg;
                                if (turn_reg ? (wr_count_reg == '0) : (rd_count_reg == '0))
                                begin
                                    served_q = ~turn_reg;
                                end
                                sq_next    = served_q;
                                state_next = S_SERVE_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                issue     = (idx_reg < sel_count);
                rv_next   = issue;
                ridx_next = idx_reg;
                if (issue)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (req_reg.cmd == CMD_SUBMIT)
                begin
                    if (rv_reg && ram_rdata.file_id == req_reg.file_id
                        && ram_rdata.offset == req_reg.block_offset)
                    begin
                        hit_next   = 1'b1;
                        sq_next    = req_reg.is_write;
                        state_next = S_APPEND;
                    end
                    else if (!issue)
                    begin
                        sq_next    = req_reg.is_write;
                        state_next = S_APPEND;
                    end
                end
                else
                begin
                    if (rv_reg && ram_rdata.tag == req_reg.request_tag)
                    begin
                        pos_next              = ridx_reg;
                        res_next.cancel_found = 1'b1;
                        state_next            = S_SHIFT_RD;
                    end
                    else if (!issue)
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_APPEND:
            begin
                res_next.hazard = hit_reg;
                if (sel_count >= CW'(QUEUE_DEPTH))
                begin
                    res_next.overflow = 1'b1;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = phys(sq_reg, sel_head, sel_count);
                    ram_wdata.tag     = req_reg.request_tag;
                    ram_wdata.file_id = req_reg.file_id;
                    ram_wdata.offset  = req_reg.block_offset;
                    if (sq_reg)
                    begin
                        wr_count_next = wr_count_reg + CW'(1);
                    end
                    else
                    begin
                        rd_count_next = rd_count_reg + CW'(1);
                    end
                end
                state_next = S_RESP;
            end
            S_SHIFT_RD:
            begin
                ram_raddr = phys(sq_reg, sel_head, pos_reg + CW'(1));
                if (pos_reg + CW'(1) < sel_count)
                begin
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    if (sq_reg)
                    begin
                        wr_count_next = wr_count_reg - CW'(1);
                    end
                    else
                    begin
                        rd_count_next = rd_count_reg - CW'(1);
                    end
                    state_next = S_RESP;
                end
            end
            S_SHIFT_WR:
            begin
                ram_we     = 1'b1;
                pos_next   = pos_reg + CW'(1);
                state_next = S_SHIFT_RD;
            end
            S_SERVE_RD:
            begin
                ram_raddr  = phys(sq_reg, sel_head, '0);
                state_next = S_SERVE_WR;
            end
            S_SERVE_WR:
            begin
                res_next.served_valid    = 1'b1;
                res_next.served_tag      = ram_rdata.tag;
                res_next.served_is_write = sq_reg;
                if (sq_reg)
                begin
                    wr_count_next = wr_count_reg - CW'(1);
                    wr_head_next  = (head_inc == SW'(QUEUE_DEPTH)) ? '0 : head_inc[PW-1:0];
                end
                else
                begin
                    rd_count_next = rd_count_reg - CW'(1);
                    rd_head_next  = (head_inc == SW'(QUEUE_DEPTH)) ? '0 : head_inc[PW-1:0];
                end
                case (mode_reg)
                    MODE_READS:  turn_next = 1'b0;
                    MODE_WRITES: turn_next = 1'b1;
                    default:     turn_next = ~sq_reg;
                endcase
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            rv_reg        <= 1'b0;
            rd_count_reg  <= '0;
            wr_count_reg  <= '0;
            rd_head_reg   <= '0;
            wr_head_reg   <= '0;
            turn_reg      <= 1'b1;
            mode_reg      <= MODE_FAIR;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            rv_reg        <= rv_next;
            rd_count_reg  <= rd_count_next;
            wr_count_reg  <= wr_count_next;
            rd_head_reg   <= rd_head_next;
            wr_head_reg   <= wr_head_next;
            turn_reg      <= turn_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
        sq_reg   <= sq_next;
        idx_reg  <= idx_next;
        ridx_reg <= ridx_next;
        hit_reg  <= hit_next;
        pos_reg  <= pos_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_count_reg <= CW'(QUEUE_DEPTH) && wr_count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_APPEND || state_reg == S_SHIFT_WR))
        else $error("ram written outside append or shift");

    a_rsp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> $onehot0({rsp_reg.hazard | rsp_reg.overflow,
                                    rsp_reg.cancel_found, rsp_reg.served_valid}))
        else $error("result mixes fields of different commands");

    a_serve_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SERVE_WR) |-> sel_count != '0)
        else $error("serve from empty queue");

endmodule

FILE: dv/tb.sv
// testbench for the read/write priority request queue with a queue and arbiter scoreboard
`timescale 1ns / 1ps
module tb;
    import rwpq_pkg::*;

    localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
    localparam int CYCLE_LIMIT = 800000;
    localparam int PHASE_ITEMS = 250;

    class queue_arbiter_scoreboard;
        entry_t read_q[$];
        entry_t write_q[$];
        logic [1:0] mode;
        bit write_turn;
        rsp_t expected_rsp[$];
        int mismatches;

        function void clear();
            read_q.delete();
            write_q.delete();
            mode = MODE_FAIR;
            write_turn = 1'b1;
            expected_rsp.delete();
            mismatches = 0;
        endfunction

        function bit phase_after(bit phase, bit served);
            if (!served)
                return !phase;
            if (mode == MODE_READS)
                return 1'b0;
            if (mode == MODE_WRITES)
                return 1'b1;
            return !phase;
        endfunction

        function void note_request(req_t r);
            rsp_t o;
            entry_t e;
            bit ph;
            o = '0;
            e.tag = r.request_tag;
            e.file_id = r.file_id;
            e.offset = r.block_offset;
            case (r.cmd)
                CMD_SUBMIT:
                begin
                    if (r.is_write)
                    begin
                        foreach (read_q[i])
                            if (read_q[i].file_id == e.file_id && read_q[i].offset == e.offset)
                                o.hazard = 1'b1;
                        if (write_q.size() >= DEPTH) o.overflow = 1'b1;
                        else write_q.insert(write_q.size(), e);
                    end
                    else
                    begin
                        foreach (write_q[i])
                            if (write_q[i].file_id == e.file_id
                                && write_q[i].offset == e.offset)
                                o.hazard = 1'b1;
                        if (read_q.size() >= DEPTH) o.overflow = 1'b1;
                        else read_q.insert(read_q.size(), e);
                    end
                end
                CMD_CANCEL:
                begin
                    if (r.is_write)
                    begin
                        foreach (write_q[i])
                            if (!o.cancel_found && write_q[i].tag == e.tag)
                            begin
                                write_q.delete(i);
                                o.cancel_found = 1'b1;
                                break;
                            end
                    end
                    else
                    begin
                        foreach (read_q[i])
                            if (!o.cancel_found && read_q[i].tag == e.tag)
                            begin
                                read_q.delete(i);
                                o.cancel_found = 1'b1;
                                break;
                            end
                    end
                end
                CMD_SERVE:
                begin
                    if (read_q.size() > 0 || write_q.size() > 0)
                    begin
                        ph = write_turn;
                        if ((ph ? write_q.size() : read_q.size()) == 0)
                            ph = phase_after(ph, 1'b0);
                        o.served_valid = 1'b1;
                        o.served_is_write = ph;
                        if (ph)
                        begin
                            o.served_tag = write_q[0].tag;
                            write_q.delete(0);
                        end
                        else
                        begin
                            o.served_tag = read_q[0].tag;
                            read_q.delete(0);
                        end
                        write_turn = phase_after(ph, 1'b1);
                    end
                end
                default: ;
            endcase
            expected_rsp.insert(expected_rsp.size(), o);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = expected_rsp[0];
            expected_rsp.delete(0);
            if (got.hazard !== want.hazard || got.overflow !== want.overflow
                || got.cancel_found !== want.cancel_found
                || got.served_valid !== want.served_valid
                || got.served_tag !== want.served_tag
                || got.served_is_write !== want.served_is_write)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_wdata;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    queue_arbiter_scoreboard sb;
    int cycles;
    bit no_idle;
    int submit_pct;
    int rsp_hold;

    read_write_priority_request_queue DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n || rsp_hold > 0)
        begin
            rsp_ready <= 1'b0;
            if (rsp_hold > 0)
                rsp_hold--;
        end
        else if (no_idle)
            rsp_ready <= 1'b1;
        else if ($urandom_range(0, 99) < 3)
        begin
            rsp_hold = $urandom_range(10, 40);
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(0, 99) < 75);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result(rsp);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_request(req_t r);
        int g;
        g = gap_len();
        @(negedge clk);
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (!req_ready);
        sb.note_request(r);
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.expected_rsp.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_mode(logic [1:0] m);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.mode = m;
    endtask

    function automatic req_t make_req(logic [1:0] c, bit w, logic [15:0] t,
                                      logic [7:0] f, logic [47:0] o);
        req_t r;
        r.cmd = c;
        r.is_write = w;
        r.request_tag = t;
        r.file_id = f;
        r.block_offset = o;
        return r;
    endfunction

    function automatic req_t random_req();
        req_t r;
        int p;
        p = $urandom_range(0, 99);
        if (p < submit_pct) r.cmd = CMD_SUBMIT;
        else if (p < submit_pct + 20) r.cmd = CMD_CANCEL;
        else if (p < 95) r.cmd = CMD_SERVE;
        else r.cmd = CMD_NOP;
        r.is_write = 1'($urandom_range(0, 1));
        r.request_tag = 16'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 31) : $urandom);
        r.file_id = 8'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom);
        r.block_offset = ($urandom_range(0, 9) < 7) ? 48'($urandom_range(0, 7))
                                                     : {16'($urandom), 32'($urandom)};
        return r;
    endfunction

    initial
    begin
        logic [1:0] modes [5];
        sb = new();
        sb.clear();
        cycles = 0;
        no_idle = 1'b0;
        submit_pct = 45;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty serve, unknown command, fill to overflow, hazard, cancels, serves
        send_request(make_req(CMD_SERVE, 1'b0, 16'h0, 8'h0, 48'h0));
        send_request(make_req(CMD_NOP, 1'b1, 16'hFFFF, 8'hFF, 48'hFFFF_FFFF_FFFF));
        for (int i = 0; i < DEPTH; i++)
            send_request(make_req(CMD_SUBMIT, 1'b0, 16'(i + 1), 8'h0, 48'(i)));
        send_request(make_req(CMD_SUBMIT, 1'b0, 16'hFFFF, 8'hFF, 48'hFFFF_FFFF_FFFF));
        send_request(make_req(CMD_SUBMIT, 1'b1, 16'h8000, 8'h0, 48'h3));
        send_request(make_req(CMD_CANCEL, 1'b0, 16'h5, 8'h0, 48'h0));
        send_request(make_req(CMD_CANCEL, 1'b0, 16'd999, 8'h0, 48'h0));
        send_request(make_req(CMD_CANCEL, 1'b1, 16'hFFFF, 8'h0, 48'h0));
        send_request(make_req(CMD_SERVE, 1'b0, 16'h0, 8'h0, 48'h0));
        send_request(make_req(CMD_SERVE, 1'b0, 16'h0, 8'h0, 48'h0));
        send_request(make_req(CMD_SERVE, 1'b0, 16'h0, 8'h0, 48'h0));

        modes = '{MODE_READS, MODE_WRITES, MODE_ALT, MODE_FAIR, MODE_WRITES};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_mode(modes[ph]);
            submit_pct = (ph % 2 == 0) ? 55 : 35;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                no_idle = (i % 100) >= 80;
                send_request(random_req());
            end
        end
        no_idle = 1'b0;
        drain();
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
